FILE: hw/rtl/vbr_pkg.sv
`timescale 1ns / 1ps

package vbr_pkg;

    localparam int DATA_W        = 8;
    localparam int ROW_BYTES_W   = 14;
    localparam int FRAME_ROWS_W  = 13;
    localparam int CUTOFF_W      = 13;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 14;
    localparam int WEIGHT_W      = 5;

    localparam int DEF_MAX_ROW_BYTES = 8192;
    localparam int DEF_MAX_ROWS      = 4096;

    localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RESET  = 14'd1440;
    localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RESET = 13'd576;
    localparam logic [CUTOFF_W-1:0]     CUTOFF_RESET     = 13'd0;

    localparam int RAMP_ROWS   = 31;
    localparam int ROUND_BIAS  = 16;
    localparam int BLEND_SHIFT = 5;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_CUTOFF = 2'd2;

    typedef enum logic [1:0] {
        MODE_SRC   = 2'd0,
        MODE_BLEND = 2'd1,
        MODE_DST   = 2'd2
    } mode_t;

    // One classified byte on its way from the front to the back.
    typedef struct packed {
        mode_t                 mode;
        logic [WEIGHT_W-1:0]   weight;
        logic [DATA_W-1:0]     dst_byte;
        logic [DATA_W-1:0]     src_byte;
        logic                  frame_end;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

FILE: hw/rtl/vbr_front.sv
`timescale 1ns / 1ps

module vbr_front
    import vbr_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = DEF_MAX_ROWS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic [DATA_W-1:0]       dst_byte,
    input  logic [DATA_W-1:0]       src_byte,
    input  logic                    q_full,
    output logic                    in_ready,
    output logic                    q_push,
    output item_t                   q_item
);

    localparam int CW  = $clog2(MAX_ROW_BYTES);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CLW = $clog2(MAX_ROW_BYTES + 1);
    localparam int RLW = $clog2(MAX_ROWS + 1);
    localparam int YW  = (RLW > CUTOFF_W ? RLW : CUTOFF_W) + 1;

    logic [ROW_BYTES_W-1:0]  row_bytes_reg;
    logic [FRAME_ROWS_W-1:0] frame_rows_reg;
    logic [CUTOFF_W-1:0]     cutoff_reg;
    logic [CW-1:0]           col_reg, col_next;
    logic [RW-1:0]           row_reg, row_next;

    logic [CLW-1:0] cols;
    logic [RLW-1:0] rows;
    logic [CW-1:0]  col_eff;
    logic [RW-1:0]  row_eff;
    logic           last_col, last_row;
    logic [YW-1:0]  y_ext, cut_ext, wdiff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg  <= ROW_BYTES_RESET;
            frame_rows_reg <= FRAME_ROWS_RESET;
            cutoff_reg     <= CUTOFF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_BYTES:    row_bytes_reg  <= cfg_data[ROW_BYTES_W-1:0];
                REG_FRAME_ROWS:   frame_rows_reg <= cfg_data[FRAME_ROWS_W-1:0];
                REG_BLEND_CUTOFF: cutoff_reg     <= cfg_data[CUTOFF_W-1:0];
                default:          ;
            endcase
        end
    end

    // A zero length counts as one; lengths past the maximum saturate.
    always_comb
    begin
        if (row_bytes_reg == '0)
            cols = CLW'(1);
        else if (32'(row_bytes_reg) > 32'(MAX_ROW_BYTES))
            cols = CLW'(MAX_ROW_BYTES);
        else
            cols = CLW'(row_bytes_reg);

        if (frame_rows_reg == '0)
            rows = RLW'(1);
        else if (32'(frame_rows_reg) > 32'(MAX_ROWS))
            rows = RLW'(MAX_ROWS);
        else
            rows = RLW'(frame_rows_reg);
    end

    // A counter left past a limit that shrank restarts at zero.
    always_comb
    begin
        col_eff  = (CLW'(col_reg) >= cols) ? '0 : col_reg;
        row_eff  = (RLW'(row_reg) >= rows) ? '0 : row_reg;
        last_col = ({1'b0, CLW'(col_eff)} + 1'b1) >= {1'b0, cols};
        last_row = ({1'b0, RLW'(row_eff)} + 1'b1) >= {1'b0, rows};

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_eff + 1'b1;
        end
        else
        begin
            col_next = col_eff + 1'b1;
            row_next = row_eff;
        end
    end

    always_comb
    begin
        y_ext   = YW'(row_eff);
        cut_ext = YW'(cutoff_reg);
        wdiff   = cut_ext - y_ext;

        if (y_ext + YW'(RAMP_ROWS) < cut_ext)
            q_item.mode = MODE_SRC;
        else if (y_ext < cut_ext && !last_row)
            q_item.mode = MODE_BLEND;
        else
            q_item.mode = MODE_DST;

        q_item.weight    = wdiff[WEIGHT_W-1:0];
        q_item.dst_byte  = dst_byte;
        q_item.src_byte  = src_byte;
        q_item.frame_end = last_col && last_row;
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (q_push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hw/rtl/vbr_queue.sv
`timescale 1ns / 1ps

module vbr_queue
    import vbr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_item,
    input  logic   pop,
    output item_t  head_item,
    output qstat_t stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    item_t          mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg, count_next;

    assign stat.full  = (count_reg == NW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/vbr_back.sv
`timescale 1ns / 1ps

module vbr_back
    import vbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             head_item,
    input  logic              q_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_byte,
    output logic              frame_end
);

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_byte_reg, out_byte_next;
    logic               frame_end_reg;

    logic signed [DATA_W:0]          diff;
    logic signed [WEIGHT_W:0]        wgt;
    logic signed [DATA_W+WEIGHT_W+1:0] prod;
    logic signed [DATA_W+WEIGHT_W+1:0] biased;
    logic signed [DATA_W+WEIGHT_W+1:0] step;

    assign pop = !q_empty && (!out_valid_reg || out_ready);

    // Rounded blend; the arithmetic shift floors negative steps.
    always_comb
    begin
        diff   = $signed({1'b0, head_item.src_byte}) - $signed({1'b0, head_item.dst_byte});
        wgt    = $signed({1'b0, head_item.weight});
        prod   = diff * wgt;
        biased = prod + (DATA_W+WEIGHT_W+2)'(ROUND_BIAS);
        step   = biased >>> BLEND_SHIFT;

        case (head_item.mode)
            MODE_SRC:   out_byte_next = head_item.src_byte;
            MODE_BLEND: out_byte_next = head_item.dst_byte + step[DATA_W-1:0];
            MODE_DST:   out_byte_next = head_item.dst_byte;
            default:    out_byte_next = head_item.dst_byte;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg  <= out_byte_next;
            frame_end_reg <= head_item.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

endmodule

FILE: hw/rtl/vertical_blend_ramp_core.sv
`timescale 1ns / 1ps

// Vertical blend ramp over a raster byte stream.
// Each request on the s_axis channel carries one destination byte and the
// co-located source byte; the block counts column and row itself and
// returns one byte per request on m_axis, with tlast marking the last byte
// of a frame. Rows well above the cutoff take the source byte, the 31 rows
// just above it take a rounded blend, and all other rows pass the
// destination byte. The last row of a frame is never blended.
// Throughput is one byte per clock while m_axis_tready is high. A taken
// request passes the queue and the output register before it shows on
// m_axis; the multiply and round sit in the back half before the output
// register. A two-entry queue parts the counting front from the back, so
// a stalled receiver lets the input run on until the queue fills.
// The cfg channel writes row_bytes (index 0), frame_rows (1) and
// blend_cutoff (2); other indexes are ignored. Always ready; users keep it
// written only while the stream is idle (unenforced). Reset restores the
// register defaults (1440, 576, 0), zeroes counters and empties the pipeline.
module vertical_blend_ramp_core
    import vbr_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = DEF_MAX_ROWS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [2*DATA_W-1:0]     s_axis_tdata,   // dst_byte[7:0], src_byte[15:8]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [DATA_W-1:0]       m_axis_tdata,   // out_byte[7:0]
    output logic                    m_axis_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    item_t  push_item, head_item;
    logic   push, pop;
    qstat_t qstat;

    assign cfg_ready = 1'b1;

    vbr_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .dst_byte  (s_axis_tdata[DATA_W-1:0]),
        .src_byte  (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .q_full    (qstat.full),
        .in_ready  (s_axis_tready),
        .q_push    (push),
        .q_item    (push_item)
    );

    vbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (qstat)
    );

    vbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_empty   (qstat.empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .frame_end (m_axis_tlast)
    );

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty together");

    a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!qstat.empty || m_axis_tvalid))
        else $error("accepted request vanished from the pipeline");

    a_stall_keeps_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && !qstat.empty) |=> !qstat.empty)
        else $error("queue drained while the output was stalled");

endmodule

FILE: tb/vertical_blend_ramp_core_tb.sv
`timescale 1ns / 1ps

module vertical_blend_ramp_core_tb;
    import vbr_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASES = 13;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              frame_end;
    } blend_out_t;

    // A register write when is_write is set, otherwise one byte pair.
    typedef struct packed {
        logic                   is_write;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [DATA_W-1:0]      dst;
        logic [DATA_W-1:0]      src;
        logic                   known;
        logic [DATA_W-1:0]      out_byte;
        logic                   frame_end;
    } script_row_t;

    localparam int SCRIPT_LEN = 23;
    localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        // Reset defaults: cutoff 0, so every byte passes the destination.
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'hFF, 8'h00, 1'b1, 8'hFF, 1'b0},
        '{1'b1, REG_UNUSED, 14'h3FFF, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h12, 8'h34, 1'b1, 8'h12, 1'b0},
        // Zero sizes act as a one-byte frame; a far cutoff selects the source.
        '{1'b1, REG_ROW_BYTES, 14'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b1, REG_FRAME_ROWS, 14'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b1, REG_BLEND_CUTOFF, 14'd4096, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h00, 8'hFF, 1'b1, 8'hFF, 1'b1},
        '{1'b1, REG_BLEND_CUTOFF, 14'h3FFF, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b1},
        // Oversized row and frame lengths saturate at the maximum.
        '{1'b1, REG_ROW_BYTES, 14'h3FFF, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b1, REG_FRAME_ROWS, 14'h3FFF, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h5A, 8'hA5, 1'b1, 8'hA5, 1'b0},
        // Three-row frames: the ramp at its short and long ends.
        '{1'b1, REG_ROW_BYTES, 14'd1, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b1, REG_FRAME_ROWS, 14'd3, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b1, REG_BLEND_CUTOFF, 14'd2, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h80, 8'h7F, 1'b0, 8'h00, 1'b0},
        '{1'b1, REG_BLEND_CUTOFF, 14'd31, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0},
        '{1'b0, REG_ROW_BYTES, 14'd0, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [2*DATA_W-1:0]    s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [DATA_W-1:0]      m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow registers and raster position of the block.
    logic [ROW_BYTES_W-1:0]  row_bytes_q = ROW_BYTES_RESET;
    logic [FRAME_ROWS_W-1:0] frame_rows_q = FRAME_ROWS_RESET;
    logic [CUTOFF_W-1:0]     cutoff_q = CUTOFF_RESET;
    int col_pos = 0;
    int row_pos = 0;

    blend_out_t awaited_bytes [$];
    int mismatch_count = 0;
    int bytes_sent = 0;
    int bytes_checked = 0;
    int frame_ends_seen = 0;
    int reg_writes = 0;
    int tx_gap_pct = 19;
    int rx_stall_pct = 60;

    vertical_blend_ramp_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic blend_out_t predict_byte(input logic [DATA_W-1:0] d,
                                                input logic [DATA_W-1:0] s);
        blend_out_t r;
        int cols;
        int rows;
        int ramp_top;
        int wt;
        int acc;
        cols = (row_bytes_q == 0) ? 1 :
               (row_bytes_q > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : int'(row_bytes_q);
        rows = (frame_rows_q == 0) ? 1 :
               (frame_rows_q > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(frame_rows_q);
        // A limit that shrank below the current position restarts that count.
        if (col_pos >= cols)
            col_pos = 0;
        if (row_pos >= rows)
            row_pos = 0;
        ramp_top = int'(cutoff_q) - RAMP_ROWS;
        if (row_pos < ramp_top)
            r.out_byte = s;
        else if (row_pos < int'(cutoff_q) && row_pos < rows - 1)
        begin
            wt = int'(cutoff_q) - row_pos;
            acc = (int'(s) - int'(d)) * wt + ROUND_BIAS;
            r.out_byte = d + DATA_W'(acc >>> BLEND_SHIFT);
        end
        else
            r.out_byte = d;
        r.frame_end = (col_pos + 1 >= cols) && (row_pos + 1 >= rows);
        if (col_pos + 1 >= cols)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        blend_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_bytes.size() == 0)
                report_mismatch("unrequested output", int'(m_axis_tdata), 0);
            else
            begin
                want = awaited_bytes.pop_front();
                bytes_checked++;
                if (m_axis_tlast)
                    frame_ends_seen++;
                if (m_axis_tdata !== want.out_byte)
                    report_mismatch("out_byte", int'(m_axis_tdata), int'(want.out_byte));
                if (m_axis_tlast !== want.frame_end)
                    report_mismatch("frame_end", int'(m_axis_tlast), int'(want.frame_end));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_pair(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] s,
                             input logic known, input blend_out_t typed);
        blend_out_t pred;
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s, d};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = predict_byte(d, s);
        awaited_bytes.push_back(known ? typed : pred);
        bytes_sent++;
    endtask

    // Lets the pipeline empty, waiting until every awaited byte is checked.
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_bytes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROW_BYTES:    row_bytes_q = val;
            REG_FRAME_ROWS:   frame_rows_q = val[FRAME_ROWS_W-1:0];
            REG_BLEND_CUTOFF: cutoff_q = val[CUTOFF_W-1:0];
            default:          ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int n_items;
        logic [CFG_DATA_W-1:0] val;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].is_write)
            begin
                drain_stream();
                write_reg(SCRIPT[i].reg_sel, SCRIPT[i].reg_val);
            end
            else
                send_pair(SCRIPT[i].dst, SCRIPT[i].src, SCRIPT[i].known,
                          '{SCRIPT[i].out_byte, SCRIPT[i].frame_end});
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 4)
            begin
                tx_gap_pct = 60;
                rx_stall_pct = 19;
            end
            else if (ph == 8)
            begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end
            drain_stream();
            // Mostly short rows and frames with a cutoff near them, so that
            // source rows, the ramp and frame wraps all come up often.
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(9))
                    0:       val = 14'd0;
                    1:       val = 14'd8192;
                    2:       val = 14'h3FFF;
                    3:       val = CFG_DATA_W'($urandom);
                    default: val = CFG_DATA_W'($urandom_range(1, 6));
                endcase
                write_reg(REG_ROW_BYTES, val);
            end
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(9))
                    0:       val = 14'd0;
                    1:       val = 14'd4096;
                    2:       val = CFG_DATA_W'($urandom);
                    default: val = CFG_DATA_W'($urandom_range(1, 48));
                endcase
                write_reg(REG_FRAME_ROWS, val);
            end
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(9))
                    0:       val = 14'd0;
                    1:       val = 14'd4096;
                    2:       val = CFG_DATA_W'($urandom);
                    default: val = CFG_DATA_W'($urandom_range(0, 80));
                endcase
                write_reg(REG_BLEND_CUTOFF, val);
            end
            if ($urandom_range(4) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

            n_items = $urandom_range(70, 130);
            for (int k = 0; k < n_items; k++)
            begin
                if (ph == 5 && k == 30)
                    drain_stream();
                send_pair(rand_byte(), rand_byte(), 1'b0, '0);
            end
        end

        drain_stream();
        repeat (10) @(posedge clk);

        $display("Sent %0d byte pairs across %0d register writes; %0d outputs checked.",
                 bytes_sent, reg_writes, bytes_checked);
        $display("Frame ends observed: %0d, mismatches: %0d.", frame_ends_seen,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/vbr_pkg.sv
hw/rtl/vbr_front.sv
hw/rtl/vbr_queue.sv
hw/rtl/vbr_back.sv
hw/rtl/vertical_blend_ramp_core.sv
tb/vertical_blend_ramp_core_tb.sv
